@@ hdl/asnt_pkg.sv @@
// shared types, constants and a helper function for the next-target pipeline
`timescale 1ns / 1ps
package asnt_pkg;

  localparam int MAX_TW    = 256;
  localparam int MAGW      = 48;
  localparam int AMTW      = 9;
  localparam int FACTW     = 17;
  localparam int POLY_BITS = 16;

  localparam logic [2:0] REG_POW_LIMIT     = 3'd0;
  localparam logic [2:0] REG_ANCHOR_BITS   = 3'd1;
  localparam logic [2:0] REG_ANCHOR_HEIGHT = 3'd2;
  localparam logic [2:0] REG_ANCHOR_PTIME  = 3'd3;
  localparam logic [2:0] REG_SPACING       = 3'd4;
  localparam logic [2:0] REG_HALF_LIFE     = 3'd5;

  localparam logic [63:0] POLY_C1  = 64'd195766423245049;
  localparam logic [63:0] POLY_C2  = 64'd971821376;
  localparam logic [63:0] POLY_C3  = 64'd5127;
  localparam logic [63:0] POLY_RND = 64'h0000_8000_0000_0000;

  localparam logic [31:0] ZERO_BITS = 32'h0101_0000;

  typedef struct packed {
    logic early;
    logic neg;
  } dside_t;

  typedef struct packed {
    logic            lim;
    logic            lsh;
    logic [AMTW-1:0] amt;
  } ctl_t;

  function automatic logic [MAX_TW-1:0] decode_bits(input logic [31:0] bits);
    logic [7:0]        size;
    logic [22:0]       mant;
    logic [4:0]        rsh;
    logic [10:0]       lsh;
    logic [MAX_TW-1:0] w;
    size = bits[31:24];
    mant = bits[22:0];
    rsh  = 5'({3'b000, 2'(8'd3 - size)} << 3);
    lsh  = {size - 8'd3, 3'b000};
    if (size <= 8'd3) begin
      w = MAX_TW'(mant >> rsh);
    end else begin
      w = MAX_TW'(mant) << lsh;
    end
    return w;
  endfunction

endpackage

@@ hdl/asnt_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module asnt_div
  import asnt_pkg::*;
#(
  parameter int QW = 64,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [QW-1:0] in_num,
  input  logic [DW-1:0] divisor,
  input  dside_t        in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output dside_t        out_side
);

  logic [QW-1:0] wq   [QW];
  logic [DW-1:0] rem  [QW];
  logic          vld  [QW];
  dside_t        side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0] src_w;
    logic [DW-1:0] src_r;
    logic          src_v;
    dside_t        src_s;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign src_w = in_num;
      assign src_r = '0;
      assign src_v = in_valid;
      assign src_s = in_side;
    end else begin : g_next
      assign src_w = wq[k-1];
      assign src_r = rem[k-1];
      assign src_v = vld[k-1];
      assign src_s = side[k-1];
    end

    assign trial = {src_r, src_w[QW-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
        wq[k]   <= {src_w[QW-2:0], ge};
        side[k] <= src_s;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = wq[QW-1];
  assign out_side  = side[QW-1];

endmodule

@@ hdl/asnt_poly.sv @@
// four-stage cubic evaluation of the 2^frac factor
`timescale 1ns / 1ps
module asnt_poly
  import asnt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [15:0]      f16,
  input  ctl_t             in_ctl,
  output logic             out_valid,
  output logic [FACTW-1:0] factor,
  output ctl_t             out_ctl
);

  logic [3:0]  vld;
  ctl_t        ctl1, ctl2, ctl3;
  logic [15:0] f1;
  logic [31:0] f2_1;
  logic [47:0] f3_2;
  logic [63:0] a1, a2, a3, b2, b3, c3;
  logic [63:0] sum;

  assign sum = a3 + b3 + c3 + POLY_RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1      <= POLY_C1 * 64'(f16);
      f2_1    <= 32'(f16) * 32'(f16);
      f1      <= f16;
      ctl1    <= in_ctl;
      b2      <= POLY_C2 * 64'(f2_1);
      f3_2    <= 48'(f2_1) * 48'(f1);
      a2      <= a1;
      ctl2    <= ctl1;
      c3      <= POLY_C3 * 64'(f3_2);
      a3      <= a2;
      b3      <= b2;
      ctl3    <= ctl2;
      factor  <= FACTW'(32'h0001_0000) + FACTW'(sum[63:48]);
      out_ctl <= ctl3;
    end
  end

  assign out_valid = vld[3];

endmodule

@@ hdl/asnt_scale.sv @@
// target multiply by factor, exponent shift and clamp to the limit
`timescale 1ns / 1ps
module asnt_scale
  import asnt_pkg::*;
#(
  parameter int TW = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [FACTW-1:0] factor,
  input  ctl_t             in_ctl,
  input  logic [TW-1:0]    anc,
  input  logic [TW-1:0]    lim,
  output logic             out_valid,
  output logic [TW-1:0]    val,
  output logic             zero
);

  localparam int NCH = (TW + 31) / 32;
  localparam int PW  = 32 + FACTW;
  localparam int SW  = NCH * 32 + 64;

  logic [NCH*32-1:0] anc_pad;
  logic [PW-1:0]     pp_w [NCH];
  logic [PW-1:0]     pp   [NCH];
  logic [SW-1:0]     even, odd, sum;
  logic [TW-1:0]     prod, sh_w, sh;
  ctl_t              ctl1, ctl2;
  logic              lim3;
  logic [3:0]        vld;

  assign anc_pad = (NCH*32)'(anc);

  for (genvar i = 0; i < NCH; i++) begin : g_pp
    assign pp_w[i] = PW'(anc_pad[32*i +: 32]) * PW'(factor);
  end

  always_comb begin
    even = '0;
    odd  = '0;
    for (int i = 0; i < NCH; i++) begin
      if (i % 2 == 0) begin
        even = even | (SW'(pp[i]) << (32 * i));
      end else begin
        odd = odd | (SW'(pp[i]) << (32 * i));
      end
    end
    sum = even + odd;
  end

  assign sh_w = ctl2.lsh ? (prod << ctl2.amt) : (prod >> ctl2.amt);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NCH; i++) begin
        pp[i] <= pp_w[i];
      end
      ctl1 <= in_ctl;
      prod <= sum[TW-1:0];
      ctl2 <= ctl1;
      sh   <= sh_w;
      lim3 <= ctl2.lim;
      val  <= (lim3 || (sh > lim)) ? lim : sh;
      zero <= !lim3 && (sh == '0);
    end
  end

  assign out_valid = vld[3];

endmodule

@@ hdl/asnt_enc.sv @@
// two-stage compact encoder of the final target
`timescale 1ns / 1ps
module asnt_enc
  import asnt_pkg::*;
#(
  parameter int TW = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [TW-1:0] val,
  input  logic          zero,
  output logic          out_valid,
  output logic [31:0]   bits
);

  logic [MAX_TW-1:0]    val256, e1_val;
  logic [5:0]           nsz, e1_nsz, n2;
  logic                 e1_zero;
  logic [MAX_TW+23:0]   ext;
  logic [23:0]          c, c2;
  logic [1:0]           vld;

  assign val256 = MAX_TW'(val);

  always_comb begin
    nsz = '0;
    for (int i = 0; i < MAX_TW / 8; i++) begin
      if (val256[8*i +: 8] != '0) begin
        nsz = 6'(i + 1);
      end
    end
  end

  assign ext = {e1_val, 24'b0};
  assign c   = ext[{e1_nsz, 3'b000} +: 24];
  assign c2  = c[23] ? {8'b0, c[23:8]} : c;
  assign n2  = c[23] ? e1_nsz + 6'd1 : e1_nsz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_val  <= val256;
      e1_nsz  <= nsz;
      e1_zero <= zero;
      bits    <= e1_zero ? ZERO_BITS : {2'b00, n2, c2};
    end
  end

  assign out_valid = vld[1];

endmodule

@@ hdl/asert_next_target.sv @@
// next-target top level: configuration registers, drift, divide and result pipeline
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the six
//   registers: 0 limit bits, 1 anchor bits, 2 anchor height, 3 anchor parent
//   time, 4 target spacing, 5 half life. cfg_ready is always high; write only
//   while no item is in flight.
//   in channel (in_valid/in_ready) takes last_height and last_time; out
//   channel (out_valid/out_ready) returns next_bits, one result per item.
//   The pipeline has three drift stages,
//   48 + FRAC_BITS divider stages (one quotient bit each), one split stage,
//   four polynomial stages, four multiply/shift/clamp stages, two encode stages.
//   Throughput is one item per cycle when not stalled; the divider pipeline sets the depth.
//   Reset restores the register defaults and empties the pipeline.
//   When out_ready is low with a result waiting, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module asert_next_target
  import asnt_pkg::*;
#(
  parameter int TARGET_WIDTH = 256,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] last_height,
  input  logic [31:0] last_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_bits
);

  localparam int QW = MAGW + FRAC_BITS;

  logic [31:0] pow_limit_bits, anchor_bits, anchor_parent_time, half_life;
  logic [30:0] anchor_height;
  logic [15:0] target_spacing;

  logic [MAX_TW-1:0]       lim_dec, anc_dec;
  logic [TARGET_WIDTH-1:0] lim_val, anc_val;

  logic en;

  // drift stages
  logic               v1, v2, v3;
  logic               early1, early2;
  logic [31:0]        hdiff1;
  logic signed [32:0] tdiff1, tdiff2;
  logic [47:0]        prod_w, prod2;
  logic signed [MAGW:0] drift;
  logic [MAGW-1:0]    mag3;
  dside_t             side3;

  // divider output and split stage
  logic           dv;
  logic [QW-1:0]  quo;
  dside_t         dside;
  logic [MAGW:0]  q1x, up_total, down, dd;
  logic [FRAC_BITS-1:0] q2, frac;
  logic [15:0]    f16_w, f16_4;
  ctl_t           ctl_w, ctl4;
  logic           v4;

  logic             pv;
  logic [FACTW-1:0] factor;
  ctl_t             pctl;

  logic                    sv, szero;
  logic [TARGET_WIDTH-1:0] sval;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pow_limit_bits     <= 32'h1d00_ffff;
      anchor_bits        <= 32'h1d00_ffff;
      anchor_height      <= '0;
      anchor_parent_time <= '0;
      target_spacing     <= 16'd600;
      half_life          <= 32'd172800;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POW_LIMIT:     pow_limit_bits     <= cfg_data;
        REG_ANCHOR_BITS:   anchor_bits        <= cfg_data;
        REG_ANCHOR_HEIGHT: anchor_height      <= cfg_data[30:0];
        REG_ANCHOR_PTIME:  anchor_parent_time <= cfg_data;
        REG_SPACING:       target_spacing     <= cfg_data[15:0];
        REG_HALF_LIFE:     half_life          <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lim_dec = decode_bits(pow_limit_bits);
  assign anc_dec = decode_bits(anchor_bits);

  always_ff @(posedge clk) begin
    lim_val <= lim_dec[TARGET_WIDTH-1:0];
    anc_val <= anc_dec[TARGET_WIDTH-1:0];
  end

  assign prod_w = 48'(target_spacing) * 48'(hdiff1);
  assign drift  = (MAGW+1)'(tdiff2) - $signed({1'b0, prod2});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      early1 <= (anchor_height == '0) || (last_height < anchor_height) ||
                (half_life == '0);
      hdiff1 <= 32'(last_height) + 32'd1 - 32'(anchor_height);
      tdiff1 <= $signed({1'b0, last_time}) - $signed({1'b0, anchor_parent_time});
      prod2  <= prod_w;
      tdiff2 <= tdiff1;
      early2 <= early1;
      side3.early <= early2;
      side3.neg   <= drift[MAGW];
      mag3   <= drift[MAGW] ? MAGW'(-drift) : drift[MAGW-1:0];
      f16_4  <= f16_w;
      ctl4   <= ctl_w;
    end
  end

  asnt_div #(.QW(QW), .DW(32)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_num    ({mag3, FRAC_BITS'(0)}),
    .divisor   (half_life),
    .in_side   (side3),
    .out_valid (dv),
    .out_quo   (quo),
    .out_side  (dside)
  );

  assign q1x      = {1'b0, quo[QW-1:FRAC_BITS]};
  assign q2       = quo[FRAC_BITS-1:0];
  assign frac     = dside.neg ? FRAC_BITS'(-q2) : q2;
  assign up_total = q1x + (MAGW+1)'(POLY_BITS);
  assign down     = q1x + (MAGW+1)'(q2 != '0);
  assign dd       = down - (MAGW+1)'(POLY_BITS);

  if (FRAC_BITS <= 16) begin : g_fup
    assign f16_w = 16'(frac) << (16 - FRAC_BITS);
  end else begin : g_fdn
    assign f16_w = 16'(frac >> (FRAC_BITS - 16));
  end

  always_comb begin
    ctl_w = '0;
    priority if (dside.early) begin
      ctl_w.lim = 1'b1;
    end else if (!dside.neg) begin
      if (up_total >= (MAGW+1)'(TARGET_WIDTH)) begin
        ctl_w.lim = 1'b1;
      end else begin
        ctl_w.lsh = 1'b1;
        ctl_w.amt = AMTW'(up_total);
      end
    end else if (down <= (MAGW+1)'(POLY_BITS)) begin
      ctl_w.lsh = 1'b1;
      ctl_w.amt = AMTW'((MAGW+1)'(POLY_BITS) - down);
    end else begin
      ctl_w.lsh = 1'b0;
      ctl_w.amt = (dd >= (MAGW+1)'(TARGET_WIDTH)) ? AMTW'(TARGET_WIDTH) : AMTW'(dd);
    end
  end

  asnt_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .f16       (f16_4),
    .in_ctl    (ctl4),
    .out_valid (pv),
    .factor    (factor),
    .out_ctl   (pctl)
  );

  asnt_scale #(.TW(TARGET_WIDTH)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pv),
    .factor    (factor),
    .in_ctl    (pctl),
    .anc       (anc_val),
    .lim       (lim_val),
    .out_valid (sv),
    .val       (sval),
    .zero      (szero)
  );

  asnt_enc #(.TW(TARGET_WIDTH)) u_enc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sv),
    .val       (sval),
    .zero      (szero),
    .out_valid (out_valid),
    .bits      (next_bits)
  );

endmodule

@@ hdl/asnt_chk.sv @@
// port-level checker for the next-target block and its bind
`timescale 1ns / 1ps
module asnt_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] next_bits
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_bits))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_form: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (next_bits[31:24] <= 8'd33) && !next_bits[23])
    else $error("malformed compact result");

endmodule

bind asert_next_target asnt_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .next_bits (next_bits)
);
